>>> hw/rtl/mrr_pkg.sv
package mrr_pkg;

   // Register file size and the widths that follow from it
   localparam int REGISTER_COUNT = 16;
   localparam int ADDR_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
   localparam int CNT_W = $clog2(REGISTER_COUNT + 1);
   localparam int REM_W = (CNT_W > 2) ? CNT_W : 2;

   // Field widths
   localparam int WORD_W = 16;
   localparam int FUNC_W = 8;
   localparam int BC_W = 6;
   localparam int PDU_W = 8;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;

   // Function codes
   localparam logic [FUNC_W-1:0] FN_READ = 8'd3;
   localparam logic [FUNC_W-1:0] FN_WRITE = 8'd6;
   localparam logic [FUNC_W-1:0] FN_DEVID = 8'd43;
   localparam logic [FUNC_W-1:0] EXC_FLAG = 8'h80;
   localparam logic [WORD_W-1:0] MAX_READ = 16'h007D;
   localparam logic [7:0] MEI_DEVID = 8'h0E;
   localparam logic [7:0] MAX_READ_CODE = 8'd4;
   localparam logic [7:0] MAX_OBJECT = 8'd2;
   localparam logic [1:0] OBJECT_COUNT = 2'd3;

   // Exception codes
   localparam logic [1:0] EX_FUNC = 2'd0;
   localparam logic [1:0] EX_ADDR = 2'd1;
   localparam logic [1:0] EX_DATA = 2'd2;
   localparam logic [1:0] EX_FAIL = 2'd3;

   // Configuration register indexes
   localparam logic [7:0] CSR_READ_MASK = 8'd0;
   localparam logic [7:0] CSR_WRITE_MASK = 8'd1;

endpackage

>>> hw/rtl/modbus_register_responder_top.sv
// Modbus holding-register responder. Each request word carries one decoded
// Modbus request; the block answers from a register file of 16 words that
// reset clears, gated per register by the read and write enable masks set
// through the csr port. A read of n registers first walks the read-enable
// bits one register per cycle, then sends n reply words one per cycle while
// the reply side accepts them, the final one with tlast; a read refused by a
// disabled register stops at that register, and a device-id reply sends up
// to three words. req_tready is high only while the single sequencer is idle,
// so the block takes no new request before it is through with the last one.
// A request with a nonzero protocol id is dropped with no reply. Errors give
// one word with tuser high and the exception code.
module modbus_register_responder_top (
   input  logic                             clock,
   input  logic                             reset,
   // csr write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [7:0]                       csr_index,
   input  logic [15:0]                      csr_data,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // protocol_id[15:0], base_addr[31:16], count_or_value[47:32],
   // write_accept[48], mei_type[56:49], read_code[64:57],
   // start_object[72:65], zero[79:73]
   input  logic [mrr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func[7:0]
   input  logic [7:0]                       req_tuser,
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // resp_function[7:0], exception_code[9:8], data_word[25:10],
   // byte_count[31:26], pdu_length[39:32]
   output logic [mrr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // is_exception[0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import mrr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_SINGLE = 3'd4;

   // Configuration
   logic [15:0] rmask_ff, wmask_ff;

   // Register file
   logic [WORD_W-1:0] reg_file_ff [REGISTER_COUNT];
   logic              reg_we;

   // Sequencer and latched request
   logic [2:0]        state_ff, state_in;
   logic [15:0]       proto_ff, proto_in;
   logic [FUNC_W-1:0] fn_ff, fn_in;
   logic [WORD_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] cv_ff, cv_in;
   logic              acc_ff, acc_in;
   logic [7:0]        mei_ff, mei_in;
   logic [7:0]        rc_ff, rc_in;
   logic [7:0]        sobj_ff, sobj_in;
   logic              exc_ff, exc_in;
   logic [1:0]        code_ff, code_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [1:0]        obj_ff, obj_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [BC_W-1:0]   bc_ff, bc_in;
   logic [PDU_W-1:0]  pdu_ff, pdu_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FUNC_W-1:0] rsp_func_ff, rsp_func_in;
   logic              rsp_exc_ff, rsp_exc_in;
   logic [1:0]        rsp_code_ff, rsp_code_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [BC_W-1:0]   rsp_bc_ff, rsp_bc_in;
   logic [PDU_W-1:0]  rsp_pdu_ff, rsp_pdu_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_take;
   logic              out_free;
   logic [16:0]       read_end;
   logic [CNT_W-1:0]  cnt;
   logic [1:0]        obj_first;
   logic [1:0]        obj_total;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign read_end  = {1'b0, addr_ff} + {1'b0, cv_ff};
   assign cnt       = cv_ff[CNT_W-1:0];
   assign obj_first = (sobj_ff > MAX_OBJECT) ? 2'd0 : sobj_ff[1:0];
   assign obj_total = OBJECT_COUNT - obj_first;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      proto_in = proto_ff;
      fn_in    = fn_ff;
      addr_in  = addr_ff;
      cv_in    = cv_ff;
      acc_in   = acc_ff;
      mei_in   = mei_ff;
      rc_in    = rc_ff;
      sobj_in  = sobj_ff;
      exc_in   = exc_ff;
      code_in  = code_ff;
      idx_in   = idx_ff;
      obj_in   = obj_ff;
      rem_in   = rem_ff;
      bc_in    = bc_ff;
      pdu_in   = pdu_ff;
      reg_we   = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_func_in  = rsp_func_ff;
      rsp_exc_in   = rsp_exc_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_bc_in    = rsp_bc_ff;
      rsp_pdu_in   = rsp_pdu_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               proto_in = req_tdata[15:0];
               fn_in    = req_tuser;
               addr_in  = req_tdata[31:16];
               cv_in    = req_tdata[47:32];
               acc_in   = req_tdata[48];
               mei_in   = req_tdata[56:49];
               rc_in    = req_tdata[64:57];
               sobj_in  = req_tdata[72:65];
               exc_in   = 1'b0;
               code_in  = EX_FUNC;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_SINGLE;
            if (proto_ff != 16'd0) begin
               // drop the request silently
               state_in = ST_IDLE;
            end else begin
               unique case (fn_ff)
                  FN_READ: begin
                     priority if (cv_ff == 16'd0 || cv_ff > MAX_READ) begin
                        exc_in  = 1'b1;
                        code_in = EX_DATA;
                     end else if (read_end > 17'(REGISTER_COUNT)) begin
                        exc_in  = 1'b1;
                        code_in = EX_ADDR;
                     end else begin
                        idx_in   = addr_ff[ADDR_W-1:0];
                        rem_in   = REM_W'(cnt);
                        bc_in    = BC_W'(cnt) << 1;
                        pdu_in   = 8'd2 + (PDU_W'(cnt) << 1);
                        state_in = ST_CHECK;
                     end
                  end
                  FN_WRITE: begin
                     priority if (addr_ff >= 16'(REGISTER_COUNT) ||
                                  !wmask_ff[addr_ff[ADDR_W-1:0]]) begin
                        exc_in  = 1'b1;
                        code_in = EX_ADDR;
                     end else if (!acc_ff) begin
                        exc_in  = 1'b1;
                        code_in = EX_FAIL;
                     end else begin
                        reg_we = 1'b1;
                     end
                  end
                  FN_DEVID: begin
                     priority if (mei_ff != MEI_DEVID) begin
                        exc_in  = 1'b1;
                        code_in = EX_FUNC;
                     end else if (rc_ff == 8'd0 || rc_ff > MAX_READ_CODE) begin
                        exc_in  = 1'b1;
                        code_in = EX_DATA;
                     end else begin
                        obj_in   = obj_first;
                        rem_in   = REM_W'(obj_total);
                        bc_in    = '0;
                        pdu_in   = 8'd7 + (PDU_W'(obj_total) << 1);
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     exc_in  = 1'b1;
                     code_in = EX_FUNC;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            // test one read-enable bit a cycle
            priority if (!rmask_ff[idx_ff]) begin
               exc_in   = 1'b1;
               code_in  = EX_FAIL;
               state_in = ST_SINGLE;
            end else if (rem_ff == REM_W'(1)) begin
               idx_in   = addr_ff[ADDR_W-1:0];
               rem_in   = REM_W'(cnt);
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
               rem_in = rem_ff - REM_W'(1);
            end
         end
         ST_EMIT: begin
            // send one reply word a cycle while the output is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_func_in  = fn_ff;
               rsp_exc_in   = 1'b0;
               rsp_code_in  = EX_FUNC;
               rsp_data_in  = (fn_ff == FN_READ) ? reg_file_ff[idx_ff] : WORD_W'(obj_ff);
               rsp_bc_in    = bc_ff;
               rsp_pdu_in   = pdu_ff;
               rsp_last_in  = (rem_ff == REM_W'(1));
               if (rem_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
                  obj_in = obj_ff + 2'd1;
                  rem_in = rem_ff - REM_W'(1);
               end
            end
         end
         ST_SINGLE: begin
            // exception or write echo
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_func_in  = exc_ff ? (fn_ff | EXC_FLAG) : fn_ff;
               rsp_exc_in   = exc_ff;
               rsp_code_in  = exc_ff ? code_ff : EX_FUNC;
               rsp_data_in  = exc_ff ? '0 : cv_ff;
               rsp_bc_in    = '0;
               rsp_pdu_in   = exc_ff ? 8'd2 : 8'd5;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rmask_ff     <= '0;
         wmask_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_READ_MASK) begin
               rmask_ff <= csr_data;
            end
            if (csr_index == CSR_WRITE_MASK) begin
               wmask_ff <= csr_data;
            end
         end
      end
   end

   // Register file: cleared at reset, one write port
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            reg_file_ff[i] <= '0;
         end
      end else if (reg_we) begin
         reg_file_ff[addr_ff[ADDR_W-1:0]] <= cv_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      proto_ff    <= proto_in;
      fn_ff       <= fn_in;
      addr_ff     <= addr_in;
      cv_ff       <= cv_in;
      acc_ff      <= acc_in;
      mei_ff      <= mei_in;
      rc_ff       <= rc_in;
      sobj_ff     <= sobj_in;
      exc_ff      <= exc_in;
      code_ff     <= code_in;
      idx_ff      <= idx_in;
      obj_ff      <= obj_in;
      rem_ff      <= rem_in;
      bc_ff       <= bc_in;
      pdu_ff      <= pdu_in;
      rsp_func_ff <= rsp_func_in;
      rsp_exc_ff  <= rsp_exc_in;
      rsp_code_ff <= rsp_code_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bc_ff   <= rsp_bc_in;
      rsp_pdu_ff  <= rsp_pdu_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pdu_ff, rsp_bc_ff, rsp_data_ff, rsp_code_ff, rsp_func_ff};
   assign rsp_tuser  = rsp_exc_ff;
   assign rsp_tlast  = rsp_last_ff;

   // An accepted request word is decoded next
   a_take_decode: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");

   // Exception words are single, empty and two bytes long
   a_exc_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tlast && rsp_data_ff == '0 && rsp_pdu_ff == 8'd2 && rsp_func_ff[7])
      else $error("malformed exception word");

   // Register file is written only when a write request decodes cleanly
   a_write_path: assert property (@(posedge clock) disable iff (reset)
      reg_we |-> state_ff == ST_DECODE && fn_ff == FN_WRITE && acc_ff)
      else $error("register file written outside a write request");

   // Walk counter never runs dry while checking or sending
   a_rem_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK || state_ff == ST_EMIT |-> rem_ff != '0)
      else $error("sequencer count ran out");

   // Read reply words carry a nonzero byte count and a PDU length two more than it
   a_read_bc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_func_ff == FN_READ |->
         rsp_bc_ff != '0 && rsp_pdu_ff == 8'd2 + PDU_W'(rsp_bc_ff))
      else $error("read word length fields disagree");

endmodule

>>> tb/sv/modbus_register_responder_top_tb.sv
module modbus_register_responder_top_tb;
   import mrr_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int TAIL_CYCLES = 40;       // longest read walk plus reply, with margin
   localparam int DRAIN_LIMIT = 20000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [7:0] CSR_UNUSED = 8'd2;

   // One decoded request and one reply word, at the block's field widths
   typedef struct packed {
      logic [15:0] protocol_id;
      logic [7:0]  func;
      logic [15:0] base_addr;
      logic [15:0] count_or_value;
      logic        write_accept;
      logic [7:0]  mei_type;
      logic [7:0]  read_code;
      logic [7:0]  start_object;
   } request_type;

   typedef struct packed {
      logic [7:0]  resp_function;
      logic        is_exception;
      logic [1:0]  exception_code;
      logic [15:0] data_word;
      logic [5:0]  byte_count;
      logic [7:0]  pdu_length;
      logic        last;
   } reply_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [7:0]            csr_index;
   logic [15:0]           csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [7:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   // Shadow of the block's state and masks
   logic [15:0] holding_regs [REGISTER_COUNT];
   logic [15:0] read_enable;
   logic [15:0] write_enable;
   reply_type   pending_replies [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int          hold_len;
   int          request_count;
   int          dropped_count;
   int          reply_count;
   int          exception_count;
   int          failure_count;

   modbus_register_responder_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic string reply_text(reply_type r);
      return $sformatf("fn=%02h exc=%0b code=%0d data=%04h bc=%0d pdu=%0d last=%0b",
                       r.resp_function, r.is_exception, r.exception_code, r.data_word,
                       r.byte_count, r.pdu_length, r.last);
   endfunction

   function automatic void report_failure(string what);
      failure_count++;
      if (failure_count <= REPORT_LIMIT)
         $display("[%0t] ERROR: %s", $realtime, what);
   endfunction

   function automatic void push_reply(logic [7:0] fn, logic exc, logic [1:0] code,
                                      logic [15:0] word, logic [5:0] bc,
                                      logic [7:0] plen, logic lst);
      reply_type r;
      r.resp_function = fn;
      r.is_exception = exc;
      r.exception_code = code;
      r.data_word = word;
      r.byte_count = bc;
      r.pdu_length = plen;
      r.last = lst;
      pending_replies.push_back(r);
   endfunction

   function automatic void push_exception(logic [7:0] fn, logic [1:0] code);
      push_reply(fn | EXC_FLAG, 1'b1, code, 16'd0, 6'd0, 8'd2, 1'b1);
   endfunction

   // Work out the reply words of one accepted request and update the shadow file
   function automatic void predict_replies(request_type r);
      int  first_reg;
      int  reg_count;
      int  first_obj;
      int  n_obj;
      logic readable;
      first_reg = int'(r.base_addr);
      reg_count = int'(r.count_or_value);
      if (r.protocol_id != 16'd0) begin
         dropped_count++;
         return;
      end
      case (r.func)
         FN_READ: begin
            if (reg_count == 0 || reg_count > int'(MAX_READ))
               push_exception(r.func, EX_DATA);
            else if (first_reg + reg_count > REGISTER_COUNT)
               push_exception(r.func, EX_ADDR);
            else begin
               readable = 1'b1;
               for (int i = 0; i < reg_count; i++)
                  if (!read_enable[first_reg + i]) readable = 1'b0;
               if (!readable)
                  push_exception(r.func, EX_FAIL);
               else
                  for (int i = 0; i < reg_count; i++)
                     push_reply(r.func, 1'b0, EX_FUNC, holding_regs[first_reg + i],
                                6'(2 * reg_count), 8'(2 + 2 * reg_count),
                                i == reg_count - 1);
            end
         end
         FN_WRITE: begin
            if (first_reg >= REGISTER_COUNT || !write_enable[r.base_addr[ADDR_W-1:0]])
               push_exception(r.func, EX_ADDR);
            else if (!r.write_accept)
               push_exception(r.func, EX_FAIL);
            else begin
               holding_regs[first_reg] = r.count_or_value;
               push_reply(r.func, 1'b0, EX_FUNC, r.count_or_value, 6'd0, 8'd5, 1'b1);
            end
         end
         FN_DEVID: begin
            if (r.mei_type != MEI_DEVID)
               push_exception(r.func, EX_FUNC);
            else if (r.read_code == 8'd0 || r.read_code > MAX_READ_CODE)
               push_exception(r.func, EX_DATA);
            else begin
               first_obj = (r.start_object > MAX_OBJECT) ? 0 : int'(r.start_object);
               n_obj = int'(OBJECT_COUNT) - first_obj;
               for (int i = 0; i < n_obj; i++)
                  push_reply(r.func, 1'b0, EX_FUNC, 16'(first_obj + i), 6'd0,
                             8'(7 + 2 * n_obj), i == n_obj - 1);
            end
         end
         default: push_exception(r.func, EX_FUNC);
      endcase
   endfunction

   // Offer one request word; return at the falling edge after acceptance, valid held high
   task automatic send_request(input request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, r.start_object, r.read_code, r.mei_type, r.write_accept,
                    r.count_or_value, r.base_addr, r.protocol_id};
      req_tuser <= r.func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_replies(r);
      request_count++;
      @(negedge clock);
   endtask

   // Request with the fields that the function ignores left random
   function automatic request_type blank_request(logic [15:0] proto, logic [7:0] fn);
      request_type r;
      r.protocol_id = proto;
      r.func = fn;
      r.base_addr = 16'($urandom);
      r.count_or_value = 16'($urandom);
      r.write_accept = 1'($urandom_range(1));
      r.mei_type = 8'($urandom);
      r.read_code = 8'($urandom);
      r.start_object = 8'($urandom);
      return r;
   endfunction

   task automatic send_read(input logic [15:0] addr, input logic [15:0] count);
      request_type r;
      r = blank_request(16'd0, FN_READ);
      r.base_addr = addr;
      r.count_or_value = count;
      send_request(r);
   endtask

   task automatic send_write(input logic [15:0] addr, input logic [15:0] value,
                             input logic accept);
      request_type r;
      r = blank_request(16'd0, FN_WRITE);
      r.base_addr = addr;
      r.count_or_value = value;
      r.write_accept = accept;
      send_request(r);
   endtask

   task automatic send_devid(input logic [7:0] mei, input logic [7:0] rcode,
                             input logic [7:0] sobj);
      request_type r;
      r = blank_request(16'd0, FN_DEVID);
      r.mei_type = mei;
      r.read_code = rcode;
      r.start_object = sobj;
      send_request(r);
   endtask

   task automatic csr_write(input logic [7:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_READ_MASK)
         read_enable = value;
      else if (index == CSR_WRITE_MASK)
         write_enable = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering, wait for every pending reply, then let the block settle
   task automatic drain_replies();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_replies.size() != 0) begin
         report_failure($sformatf("%0d reply words never arrived", pending_replies.size()));
         pending_replies.delete();
      end
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [15:0] rmask, input logic [15:0] wmask);
      drain_replies();
      csr_write(CSR_READ_MASK, rmask);
      csr_write(CSR_WRITE_MASK, wmask);
   endtask

   // Mostly well-formed reads and writes, with device id, stray codes and dropped requests
   function automatic request_type random_request();
      request_type r;
      int unsigned pick;
      int unsigned span;
      r = blank_request(16'd0, 8'($urandom_range(255)));
      r.write_accept = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (pick < 8) begin
         r.protocol_id = 16'($urandom_range(65535, 1));
         r.func = ($urandom_range(1) != 0) ? FN_READ : FN_WRITE;
      end else if (pick < 50) begin
         r.func = FN_READ;
         if ($urandom_range(9) != 0) begin
            r.base_addr = 16'($urandom_range(REGISTER_COUNT - 1));
            span = REGISTER_COUNT - int'(r.base_addr);
            r.count_or_value = ($urandom_range(3) == 0)
                                  ? 16'($urandom_range(span, 1))
                                  : 16'($urandom_range(span < 4 ? span : 4, 1));
         end
      end else if (pick < 80) begin
         r.func = FN_WRITE;
         if ($urandom_range(9) != 0)
            r.base_addr = 16'($urandom_range(REGISTER_COUNT - 1));
      end else if (pick < 92) begin
         r.func = FN_DEVID;
         if ($urandom_range(9) != 0) r.mei_type = MEI_DEVID;
         if ($urandom_range(9) != 0) r.read_code = 8'($urandom_range(4, 1));
         if ($urandom_range(4) != 0) r.start_object = 8'($urandom_range(3));
      end
      return r;
   endfunction

   // Reads of a freshly cleared file return zeros
   task automatic test_cleared_file();
      configure(16'hFFFF, 16'hFFFF);
      send_read(16'd0, 16'd16);
      send_read(16'd15, 16'd1);
   endtask

   task automatic test_read_write();
      send_write(16'd0, 16'hFFFF, 1'b1);
      send_write(16'd15, 16'hA5C3, 1'b1);
      send_write(16'd7, 16'h1234, 1'b0);      // host refuses, nothing stored
      send_write(16'd16, 16'h5555, 1'b1);     // just past the file
      send_read(16'd0, 16'd16);
      send_read(16'd0, 16'd0);                // empty count
      send_read(16'd0, 16'h007D);             // largest legal count, range too long
      send_read(16'd0, 16'h007E);
      send_read(16'd0, 16'hFFFF);
      send_read(16'hFFFF, 16'd1);             // start far outside the file
   endtask

   task automatic test_enable_masks();
      configure(16'hFFFE, 16'h7FFF);
      send_read(16'd0, 16'd2);                // one disabled register fails the lot
      send_read(16'd1, 16'd15);
      send_write(16'd15, 16'h0F0F, 1'b1);
      send_write(16'd14, 16'hBEEF, 1'b1);
      drain_replies();
      csr_write(CSR_UNUSED, 16'h0000);        // unused index leaves the masks alone
      send_read(16'd14, 16'd1);
      configure(16'h0000, 16'h0000);
      send_read(16'd15, 16'd1);
      send_write(16'd0, 16'h0001, 1'b1);
   endtask

   task automatic test_device_id();
      send_devid(MEI_DEVID, 8'd1, 8'd0);
      send_devid(MEI_DEVID, 8'd4, 8'd2);
      send_devid(MEI_DEVID, 8'd2, 8'hFF);     // out-of-range object starts at zero
      send_devid(8'h0D, 8'd1, 8'd0);
      send_devid(MEI_DEVID, 8'd0, 8'd1);
      send_devid(MEI_DEVID, 8'd5, 8'd1);
   endtask

   task automatic test_function_codes();
      request_type r;
      configure(16'hFFFF, 16'hFFFF);
      send_request(blank_request(16'd0, 8'h00));
      send_request(blank_request(16'd0, 8'hFF));
      send_request(blank_request(16'd0, FN_READ | EXC_FLAG));
      // dropped write must not touch the file
      r = blank_request(16'hFFFF, FN_WRITE);
      r.base_addr = 16'd3;
      send_request(r);
      r = blank_request(16'h0001, FN_READ);
      r.base_addr = 16'd0;
      r.count_or_value = 16'd4;
      send_request(r);
      send_read(16'd3, 16'd1);
   endtask

   // Hold the reply side off while requests keep coming, so the input stalls
   task automatic test_reply_backpressure();
      configure(16'hFFFF, 16'hFFFF);
      hold_len = 400;
      for (int i = 0; i < 10; i++) begin
         if (i % 3 == 2)
            send_write(16'($urandom_range(REGISTER_COUNT - 1)), 16'($urandom), 1'b1);
         else
            send_read(16'd0, 16'd16);
      end
   endtask

   task automatic test_random_traffic(input int n_items, input int unsigned send_pct,
                                      input int unsigned recv_pct,
                                      input logic [15:0] rmask, input logic [15:0] wmask);
      configure(rmask, wmask);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < n_items; i++)
         send_request(random_request());
   endtask

   // Reply side: random stalls, or one long hold when asked
   initial begin : reply_sink
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len != 0) begin
            stall = hold_len;
            hold_len = 0;
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Compare each accepted reply word with the oldest prediction
   always @(posedge clock) begin : reply_checker
      reply_type got;
      reply_type want;
      string     diff;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.resp_function = rsp_tdata[7:0];
         got.exception_code = rsp_tdata[9:8];
         got.data_word = rsp_tdata[25:10];
         got.byte_count = rsp_tdata[31:26];
         got.pdu_length = rsp_tdata[39:32];
         got.is_exception = rsp_tuser;
         got.last = rsp_tlast;
         reply_count++;
         if (got.is_exception === 1'b1) exception_count++;
         if (pending_replies.size() == 0) begin
            report_failure({"reply word with none pending: ", reply_text(got)});
         end else begin
            want = pending_replies.pop_front();
            diff = "";
            if (got.resp_function !== want.resp_function) diff = {diff, " resp_function"};
            if (got.is_exception !== want.is_exception) diff = {diff, " is_exception"};
            if (got.exception_code !== want.exception_code) diff = {diff, " exception_code"};
            if (got.data_word !== want.data_word) diff = {diff, " data_word"};
            if (got.byte_count !== want.byte_count) diff = {diff, " byte_count"};
            if (got.pdu_length !== want.pdu_length) diff = {diff, " pdu_length"};
            if (got.last !== want.last) diff = {diff, " last"};
            if (diff != "")
               report_failure($sformatf("mismatch in%s: expected %s, got %s", diff,
                                        reply_text(want), reply_text(got)));
         end
      end
   end

   initial begin : watchdog
      #8000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : test_sequence
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = 8'd0;
      csr_data = 16'd0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 8'd0;
      read_enable = 16'd0;
      write_enable = 16'd0;
      for (int i = 0; i < REGISTER_COUNT; i++) holding_regs[i] = 16'd0;
      send_idle_pct = 14;
      recv_idle_pct = 55;
      hold_len = 0;
      request_count = 0;
      dropped_count = 0;
      reply_count = 0;
      exception_count = 0;
      failure_count = 0;

      // hold reset, release on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_cleared_file();
      test_read_write();
      test_enable_masks();
      test_device_id();
      test_function_codes();
      test_random_traffic(40, 14, 55, 16'hFFFF & ~(16'h1 << $urandom_range(15)),
                          16'($urandom | $urandom));
      send_idle_pct = 55;
      recv_idle_pct = 14;
      test_reply_backpressure();
      test_random_traffic(40, 55, 14, 16'hFFFF, 16'hFFFF);
      test_random_traffic(40, 0, 0, 16'($urandom | $urandom), 16'($urandom));
      drain_replies();

      $display("Covered reads, writes, device id, bad codes and dropped requests under");
      $display("three idle mixes and a long reply hold: %0d requests (%0d dropped),",
               request_count, dropped_count);
      $display("%0d reply words, %0d exceptions.", reply_count, exception_count);
      if (failure_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
